// ===== rtl/http_get_request_parser_macros.svh =====
// assertion macros for the request line parser
`ifndef HTTP_GET_REQUEST_PARSER_MACROS_SVH
`define HTTP_GET_REQUEST_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HGRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HGRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HGRP_ASSERT_IMP(lbl, ante, cons, msg)
`define HGRP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/hgrp_pkg.sv =====
`default_nettype none

package hgrp_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CFG_BITS   = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  localparam logic [CFG_BITS-1:0] MAX_LINE_RST   = 16'd1024;
  localparam logic [CFG_BITS-1:0] MAX_HEADER_RST = 16'd4096;

  localparam logic [31:0] END_MARK  = 32'h0D0A_0D0A;
  localparam logic [31:0] EXT_JPG   = 32'h2E6A_7067;
  localparam logic [31:0] EXT_PNG   = 32'h2E70_6E67;
  localparam logic [31:0] EXT_GIF   = 32'h2E67_6966;
  localparam logic [23:0] EXT_JS    = 24'h2E6A73;
  localparam logic [23:0] DOT_DOT_SLASH = 24'h2E2E2F;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  typedef enum logic [0:0] {
    CFG_MAX_LINE   = 1'b0,
    CFG_MAX_HEADER = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_PATH    = 4'd1,
    PH_ARGS    = 4'd2,
    PH_PROTO   = 4'd3,
    PH_VERSION = 4'd4,
    PH_CR      = 4'd5,
    PH_LF      = 4'd6,
    PH_HEADER  = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_METHOD   = 3'd1,
    ST_PATH_ERR     = 3'd2,
    ST_BAD_PROTO    = 3'd3,
    ST_BAD_VERSION  = 3'd4,
    ST_BAD_LINE_END = 3'd5,
    ST_LINE_LONG    = 3'd6,
    ST_HEADER_LONG  = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    KIND_HTML = 3'd0,
    KIND_JS   = 3'd1,
    KIND_JPEG = 3'd2,
    KIND_PNG  = 3'd3,
    KIND_GIF  = 3'd4
  } kind_e;

  typedef struct packed {
    phase_e                phase;
    logic [COUNT_BITS-1:0] line_count;
    logic [COUNT_BITS-1:0] header_count;
    logic [1:0]            method_count;
    logic                  method_match;
    logic [COUNT_BITS-1:0] path_count;
    logic [31:0]           path_tail;
    logic [31:0]           recent_bytes;
    logic                  traversal_seen;
    logic [2:0]            protocol_index;
    logic                  version_digit;
    logic                  finished;
  } parse_state_t;

  typedef struct packed {
    status_e               status;
    logic                  minor_version;
    logic [COUNT_BITS-1:0] path_length;
    kind_e                 content_kind;
    logic                  path_traversal;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/hgrp_in_if.sv =====
`default_nettype none

interface hgrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_request;

  modport source (output valid, output data_byte, output start_request, input ready);
  modport sink   (input valid, input data_byte, input start_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/hgrp_out_if.sv =====
`default_nettype none

interface hgrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        minor_version;
  logic [15:0] path_length;
  logic [2:0]  content_kind;
  logic        path_traversal;

  modport source (output valid, output status, output minor_version, output path_length,
                  output content_kind, output path_traversal, input ready);
  modport sink   (input valid, input status, input minor_version, input path_length,
                  input content_kind, input path_traversal, output ready);
endinterface

`default_nettype wire

// ===== rtl/hgrp_parse.sv =====
`default_nettype none

module hgrp_parse (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [7:0]                    byte_i,
  input  wire logic                          start_i,
  input  wire logic [hgrp_pkg::CFG_BITS-1:0] max_line_i,
  input  wire logic [hgrp_pkg::CFG_BITS-1:0] max_header_i,
  output logic                               res_valid_o,
  output hgrp_pkg::result_t                  res_o
);

  hgrp_pkg::parse_state_t state_q, state_d, clr_state;
  logic                   emit;
  hgrp_pkg::status_e      emit_status;
  logic [7:0]             low_b;
  logic                   is_letter;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    case (idx)
      2'd0:    get_char = 8'h67;
      2'd1:    get_char = 8'h65;
      2'd2:    get_char = 8'h74;
      default: get_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    case (idx)
      3'd0:    proto_char = 8'h68;
      3'd1:    proto_char = 8'h74;
      3'd2:    proto_char = 8'h74;
      3'd3:    proto_char = 8'h70;
      3'd4:    proto_char = 8'h2F;
      3'd5:    proto_char = 8'h31;
      3'd6:    proto_char = 8'h2E;
      default: proto_char = 8'h00;
    endcase
  endfunction

  always_comb begin
    clr_state                = '0;
    clr_state.phase          = hgrp_pkg::PH_METHOD;
    clr_state.method_match   = 1'b1;
  end

  assign low_b     = (byte_i >= 8'h41 && byte_i <= 8'h5A) ? byte_i + 8'd32 : byte_i;
  assign is_letter = (low_b >= 8'h61 && low_b <= 8'h7A);

  // next state
  always_comb begin
    state_d     = start_i ? clr_state : state_q;
    emit        = 1'b0;
    emit_status = hgrp_pkg::ST_OK;
    if (!state_d.finished) begin
      state_d.recent_bytes = {state_d.recent_bytes[23:0], byte_i};
      if (state_d.phase == hgrp_pkg::PH_HEADER) begin
        if (state_d.header_count >= max_header_i || state_d.header_count == hgrp_pkg::CNT_MAX) begin
          emit        = 1'b1;
          emit_status = hgrp_pkg::ST_HEADER_LONG;
        end else begin
          state_d.header_count = state_d.header_count + hgrp_pkg::CNT_ONE;
          if (state_d.recent_bytes == hgrp_pkg::END_MARK) begin
            emit        = 1'b1;
            emit_status = hgrp_pkg::ST_OK;
          end
        end
      end else if (state_d.line_count >= max_line_i || state_d.line_count == hgrp_pkg::CNT_MAX) begin
        emit        = 1'b1;
        emit_status = hgrp_pkg::ST_LINE_LONG;
      end else begin
        state_d.line_count = state_d.line_count + hgrp_pkg::CNT_ONE;
        case (state_d.phase)
          hgrp_pkg::PH_METHOD: begin
            if (is_letter) begin
              if (state_d.method_count == 2'd3) begin
                emit        = 1'b1;
                emit_status = hgrp_pkg::ST_BAD_METHOD;
              end else begin
                if (low_b != get_char(state_d.method_count)) state_d.method_match = 1'b0;
                state_d.method_count = state_d.method_count + 2'd1;
              end
            end else if (byte_i == hgrp_pkg::CH_SPACE && state_d.method_count == 2'd3 &&
                         state_d.method_match) begin
              state_d.phase = hgrp_pkg::PH_PATH;
            end else begin
              emit        = 1'b1;
              emit_status = hgrp_pkg::ST_BAD_METHOD;
            end
          end
          hgrp_pkg::PH_PATH: begin
            if (byte_i == hgrp_pkg::CH_SPACE) begin
              state_d.phase = hgrp_pkg::PH_PROTO;
            end else if (byte_i == hgrp_pkg::CH_QUERY || byte_i == hgrp_pkg::CH_CR) begin
              state_d.phase = hgrp_pkg::PH_ARGS;
            end else if (state_d.path_count == hgrp_pkg::CNT_MAX) begin
              emit        = 1'b1;
              emit_status = hgrp_pkg::ST_PATH_ERR;
            end else begin
              state_d.path_count = state_d.path_count + hgrp_pkg::CNT_ONE;
              state_d.path_tail  = {state_d.path_tail[23:0], byte_i};
              if (state_d.path_count >= 16'd3 &&
                  state_d.path_tail[23:0] == hgrp_pkg::DOT_DOT_SLASH) begin
                state_d.traversal_seen = 1'b1;
              end
            end
          end
          hgrp_pkg::PH_ARGS: begin
            if (byte_i == hgrp_pkg::CH_SPACE) state_d.phase = hgrp_pkg::PH_PROTO;
          end
          hgrp_pkg::PH_PROTO: begin
            if (state_d.protocol_index > 3'd6 ||
                low_b != proto_char(state_d.protocol_index)) begin
              emit        = 1'b1;
              emit_status = hgrp_pkg::ST_BAD_PROTO;
            end else begin
              state_d.protocol_index = state_d.protocol_index + 3'd1;
              if (state_d.protocol_index == 3'd7) state_d.phase = hgrp_pkg::PH_VERSION;
            end
          end
          hgrp_pkg::PH_VERSION: begin
            if (byte_i != hgrp_pkg::CH_ZERO && byte_i != hgrp_pkg::CH_ONE) begin
              emit        = 1'b1;
              emit_status = hgrp_pkg::ST_BAD_VERSION;
            end else begin
              state_d.version_digit = byte_i[0];
              state_d.phase         = hgrp_pkg::PH_CR;
            end
          end
          hgrp_pkg::PH_CR: begin
            if (byte_i != hgrp_pkg::CH_CR) begin
              emit        = 1'b1;
              emit_status = hgrp_pkg::ST_BAD_LINE_END;
            end else begin
              state_d.phase = hgrp_pkg::PH_LF;
            end
          end
          hgrp_pkg::PH_LF: begin
            if (byte_i != hgrp_pkg::CH_LF) begin
              emit        = 1'b1;
              emit_status = hgrp_pkg::ST_BAD_LINE_END;
            end else begin
              state_d.phase = hgrp_pkg::PH_HEADER;
            end
          end
          default: begin
            state_d.phase = hgrp_pkg::PH_METHOD;
            emit          = 1'b1;
            emit_status   = hgrp_pkg::ST_BAD_METHOD;
          end
        endcase
      end
    end
    if (emit) state_d.finished = 1'b1;
  end

  // result fields, taken from the state as it stands once this byte is applied
  always_comb begin
    res_valid_o          = fire_i && emit;
    res_o.status         = emit_status;
    res_o.minor_version  = state_d.version_digit;
    res_o.path_length    = state_d.path_count;
    res_o.path_traversal = state_d.traversal_seen;
    res_o.content_kind   = hgrp_pkg::KIND_HTML;
    if (state_d.path_count > 16'd3 && state_d.path_tail == hgrp_pkg::EXT_JPG) begin
      res_o.content_kind = hgrp_pkg::KIND_JPEG;
    end else if (state_d.path_count > 16'd3 && state_d.path_tail == hgrp_pkg::EXT_PNG) begin
      res_o.content_kind = hgrp_pkg::KIND_PNG;
    end else if (state_d.path_count > 16'd3 && state_d.path_tail == hgrp_pkg::EXT_GIF) begin
      res_o.content_kind = hgrp_pkg::KIND_GIF;
    end else if (state_d.path_count > 16'd2 && state_d.path_tail[23:0] == hgrp_pkg::EXT_JS) begin
      res_o.content_kind = hgrp_pkg::KIND_JS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clr_state;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/http_get_request_parser.sv =====
// result: a result is registered in the result buffer when the input register passes on the byte
// that ends the request line, the header or the request on an error
// throughput: one byte per cycle while the skid entry is empty, set by the single-pass
// parser between input and result registers; a two-entry result buffer lets bytes keep
// flowing while a result waits; the input stalls only while both result entries are full
// reset: asynchronous, clears the parser and buffers and restores both length limits
`default_nettype none

`include "http_get_request_parser_macros.svh"

module http_get_request_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hgrp_in_if.sink                            in_i,
  hgrp_out_if.source                         out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [hgrp_pkg::CFG_BITS-1:0] cfg_wdata_i
);

  logic [hgrp_pkg::CFG_BITS-1:0] max_line_q, max_header_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       accept, fire;

  logic              res_valid;
  hgrp_pkg::result_t res;

  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  hgrp_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              pop, push;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q   <= hgrp_pkg::MAX_LINE_RST;
      max_header_q <= hgrp_pkg::MAX_HEADER_RST;
    end else if (cfg_we_i) begin
      case (hgrp_pkg::cfg_idx_e'(cfg_idx_i))
        hgrp_pkg::CFG_MAX_LINE:   max_line_q   <= cfg_wdata_i;
        hgrp_pkg::CFG_MAX_HEADER: max_header_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  assign fire       = in_valid_q && !skid_valid_q;
  assign in_i.ready = !in_valid_q || fire;
  assign accept     = in_i.valid && in_i.ready;
  assign in_valid_d = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.start_request;
    end
  end

  hgrp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_i       (in_byte_q),
    .start_i      (in_start_q),
    .max_line_i   (max_line_q),
    .max_header_i (max_header_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register with skid entry
  assign pop  = out_valid_q && out_o.ready;
  assign push = res_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.minor_version  = out_q.minor_version;
  assign out_o.path_length    = out_q.path_length;
  assign out_o.content_kind   = out_q.content_kind;
  assign out_o.path_traversal = out_q.path_traversal;

  `HGRP_ASSERT_IMP(a_skid_has_main, skid_valid_q, out_valid_q, "skid entry without main entry")
  `HGRP_ASSERT_IMP(a_res_on_fire, res_valid, fire, "result without a byte in process")
  `HGRP_ASSERT_IMP(a_empty_ready, !in_valid_q, in_i.ready, "empty input register not ready")
  `HGRP_ASSERT_NXT(a_skid_fill, push && out_valid_q && !pop, skid_valid_q, "result not held")

endmodule

`default_nettype wire

// ===== bench/hgrp_response_check.sv =====
`default_nettype none

module hgrp_response_check
  import hgrp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  hgrp_in_if                  byte_mon_i,
  hgrp_out_if                 result_mon_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  predicted_o,
  output int                  checked_o,
  output logic [7:0]          status_seen_o
);

  localparam logic [23:0] METHOD_WORD = "get";
  localparam logic [55:0] PROTO_WORD  = "http/1.";

  logic [CFG_BITS-1:0]   line_limit;
  logic [CFG_BITS-1:0]   header_limit;

  phase_e                ph;
  logic [COUNT_BITS-1:0] line_cnt;
  logic [COUNT_BITS-1:0] hdr_cnt;
  logic [COUNT_BITS-1:0] path_cnt;
  logic [1:0]            meth_cnt;
  logic                  meth_ok;
  logic [31:0]           path_tail;
  logic [31:0]           recent;
  logic                  traversal;
  logic [2:0]            proto_idx;
  logic                  version;
  logic                  done;

  result_t               expected_q[$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] l;
    l = fold_case(c);
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic kind_e path_kind();
    if (path_cnt > 3) begin
      if (path_tail == EXT_JPG) return KIND_JPEG;
      if (path_tail == EXT_PNG) return KIND_PNG;
      if (path_tail == EXT_GIF) return KIND_GIF;
    end
    if (path_cnt > 2 && path_tail[23:0] == EXT_JS) return KIND_JS;
    return KIND_HTML;
  endfunction

  task automatic clear_parser();
    ph        = PH_METHOD;
    line_cnt  = '0;
    hdr_cnt   = '0;
    path_cnt  = '0;
    meth_cnt  = '0;
    meth_ok   = 1'b1;
    path_tail = '0;
    recent    = '0;
    traversal = 1'b0;
    proto_idx = '0;
    version   = 1'b0;
    done      = 1'b0;
  endtask

  task automatic report(input string msg);
    fail_count_o++;
    if (fail_count_o <= 40) $display("mismatch: %s", msg);
  endtask

  // advances the parser by one byte, hit is set when the byte ends the request
  task automatic parse_byte(input logic [7:0] b, input logic restart,
                            output logic hit, output status_e st);
    hit = 1'b0;
    st  = ST_OK;
    if (restart) clear_parser();
    if (done) return;
    recent = {recent[23:0], b};
    if (ph == PH_HEADER) begin
      if (hdr_cnt >= header_limit || hdr_cnt == CNT_MAX) begin
        hit = 1'b1;
        st  = ST_HEADER_LONG;
      end else begin
        hdr_cnt++;
        if (recent == END_MARK) hit = 1'b1;
      end
    end else if (line_cnt >= line_limit || line_cnt == CNT_MAX) begin
      hit = 1'b1;
      st  = ST_LINE_LONG;
    end else begin
      line_cnt++;
      case (ph)
        PH_METHOD: begin
          if (is_letter(b)) begin
            if (meth_cnt == 2'd3) begin
              hit = 1'b1;
              st  = ST_BAD_METHOD;
            end else begin
              if (fold_case(b) != METHOD_WORD[8*(2-int'(meth_cnt)) +: 8]) meth_ok = 1'b0;
              meth_cnt++;
            end
          end else if (b == CH_SPACE && meth_cnt == 2'd3 && meth_ok) begin
            ph = PH_PATH;
          end else begin
            hit = 1'b1;
            st  = ST_BAD_METHOD;
          end
        end
        PH_PATH: begin
          if (b == CH_SPACE) begin
            ph = PH_PROTO;
          end else if (b == CH_QUERY || b == CH_CR) begin
            ph = PH_ARGS;
          end else if (path_cnt == CNT_MAX) begin
            hit = 1'b1;
            st  = ST_PATH_ERR;
          end else begin
            path_cnt++;
            path_tail = {path_tail[23:0], b};
            if (path_cnt >= 3 && path_tail[23:0] == DOT_DOT_SLASH) traversal = 1'b1;
          end
        end
        PH_ARGS: begin
          if (b == CH_SPACE) ph = PH_PROTO;
        end
        PH_PROTO: begin
          if (proto_idx > 3'd6) begin
            hit = 1'b1;
            st  = ST_BAD_PROTO;
          end else if (fold_case(b) != PROTO_WORD[8*(6-int'(proto_idx)) +: 8]) begin
            hit = 1'b1;
            st  = ST_BAD_PROTO;
          end else begin
            proto_idx++;
            if (proto_idx == 3'd7) ph = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (b != CH_ZERO && b != CH_ONE) begin
            hit = 1'b1;
            st  = ST_BAD_VERSION;
          end else begin
            version = b[0];
            ph      = PH_CR;
          end
        end
        PH_CR: begin
          if (b != CH_CR) begin
            hit = 1'b1;
            st  = ST_BAD_LINE_END;
          end else begin
            ph = PH_LF;
          end
        end
        PH_LF: begin
          if (b != CH_LF) begin
            hit = 1'b1;
            st  = ST_BAD_LINE_END;
          end else begin
            ph = PH_HEADER;
          end
        end
        default: begin
          ph  = PH_METHOD;
          hit = 1'b1;
          st  = ST_BAD_METHOD;
        end
      endcase
    end
    if (hit) done = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    logic    hit;
    status_e st;
    if (!rst_ni) begin
      line_limit   = MAX_LINE_RST;
      header_limit = MAX_HEADER_RST;
      clear_parser();
      expected_q.delete();
      fail_count_o  = 0;
      predicted_o   = 0;
      checked_o     = 0;
      status_seen_o = '0;
    end else begin
      // results first: a byte taken at this edge cannot have produced one yet
      if (result_mon_i.valid && result_mon_i.ready) begin
        got.status         = status_e'(result_mon_i.status);
        got.minor_version  = result_mon_i.minor_version;
        got.path_length    = result_mon_i.path_length;
        got.content_kind   = kind_e'(result_mon_i.content_kind);
        got.path_traversal = result_mon_i.path_traversal;
        checked_o++;
        status_seen_o[got.status] = 1'b1;
        if (expected_q.size() == 0) begin
          report($sformatf("result %0d (status %0d) arrived with nothing expected",
                           checked_o, got.status));
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             checked_o, got.status, want.status));
          if (got.minor_version != want.minor_version)
            report($sformatf("result %0d minor version %0d, expected %0d",
                             checked_o, got.minor_version, want.minor_version));
          if (got.path_length != want.path_length)
            report($sformatf("result %0d path length %0d, expected %0d",
                             checked_o, got.path_length, want.path_length));
          if (got.content_kind != want.content_kind)
            report($sformatf("result %0d content kind %0d, expected %0d",
                             checked_o, got.content_kind, want.content_kind));
          if (got.path_traversal != want.path_traversal)
            report($sformatf("result %0d traversal flag %0d, expected %0d",
                             checked_o, got.path_traversal, want.path_traversal));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_LINE:   line_limit   = cfg_wdata_i;
          CFG_MAX_HEADER: header_limit = cfg_wdata_i;
          default: ;
        endcase
      end
      if (byte_mon_i.valid && byte_mon_i.ready) begin
        parse_byte(byte_mon_i.data_byte, byte_mon_i.start_request, hit, st);
        if (hit) begin
          want.status         = st;
          want.minor_version  = version;
          want.path_length    = path_cnt;
          want.content_kind   = path_kind();
          want.path_traversal = traversal;
          expected_q.push_back(want);
          predicted_o++;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/http_get_request_parser_test.sv =====
`default_nettype none

module http_get_request_parser_test;
  import hgrp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int LONG_RUN    = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CFG_BITS-1:0] cfg_wdata;

  int                  fail_count;
  int                  predicted;
  int                  checked;
  int                  pending;
  logic [7:0]          status_seen;

  logic [7:0]          req_q[$];
  int                  burst_left;
  int                  total_bytes;
  int                  n_requests;
  int                  quiet;
  bit                  hold_go;
  string               word_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_~%=&";

  hgrp_in_if  in_if ();
  hgrp_out_if out_if ();

  http_get_request_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  hgrp_response_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_mon_i    (in_if),
    .result_mon_i  (out_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .predicted_o   (predicted),
    .checked_o     (checked),
    .status_seen_o (status_seen)
  );

  assign pending = predicted - checked;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: stall patterns, plus a long hold-off when asked
  initial begin : result_sink
    int mode;
    int len;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding", quiet, pending);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.start_request <= restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    total_bytes++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [CFG_BITS-1:0] line_lim,
                            input logic [CFG_BITS-1:0] hdr_lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAX_LINE;
    cfg_wdata <= line_lim;
    @(posedge clk_i);
    cfg_idx   <= CFG_MAX_HEADER;
    cfg_wdata <= hdr_lim;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_text(input string s, input bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1))
        c = c ^ 8'h20;
      req_q.push_back(c);
    end
  endtask

  task automatic push_word(input int n);
    repeat (n) req_q.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
  endtask

  task automatic push_crlf();
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
  endtask

  task automatic send_queue(input logic first_start, input int restart_at);
    for (int i = 0; i < req_q.size(); i++)
      send_byte(req_q[i], (i == 0) ? first_start : (i == restart_at));
    n_requests++;
  endtask

  // mostly well-formed requests with random content, some damaged, some noise
  task automatic make_request();
    int pick;
    int n;
    req_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 12);
      repeat (n) req_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    pick = $urandom_range(0, 19);
    if (pick < 15)       push_text("GET ", 1);
    else if (pick == 15) push_text("GEX ", 1);
    else if (pick == 16) push_text("GE ", 1);
    else if (pick == 17) push_text("GETT ", 1);
    else if (pick == 18) push_text("GET/", 0);
    else                 push_text("HEAD ", 0);
    if ($urandom_range(0, 19) != 0) begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1:    push_text("/", 0);
          2:       push_text("../", 0);
          3:       push_text("..", 0);
          4:       push_text(".", 0);
          5:       req_q.push_back(8'($urandom_range(0, 255)));
          default: push_word($urandom_range(1, 4));
        endcase
      end
      case ($urandom_range(0, 9))
        0:       push_text(".js", 0);
        1:       push_text(".jpg", 0);
        2:       push_text(".png", 0);
        3:       push_text(".gif", 0);
        4:       push_text(".JPG", 0);
        5:       push_text(".html", 0);
        default: ;
      endcase
    end
    pick = $urandom_range(0, 9);
    if (pick >= 7) begin
      req_q.push_back((pick < 9) ? CH_QUERY : CH_CR);
      push_word($urandom_range(0, 6));
      if ($urandom_range(0, 3) == 0) req_q.push_back(CH_QUERY);
      if ($urandom_range(0, 5) == 0) req_q.push_back(CH_CR);
    end
    req_q.push_back(CH_SPACE);
    push_text("HTTP/1.", 1);
    if ($urandom_range(0, 11) == 0)
      req_q[req_q.size() - 1 - $urandom_range(0, 6)] = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 5)      req_q.push_back(CH_ONE);
    else if (pick < 9) req_q.push_back(CH_ZERO);
    else               req_q.push_back(8'($urandom_range(0, 255)));
    push_crlf();
    if ($urandom_range(0, 19) == 0)
      req_q[req_q.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
    n = $urandom_range(0, 3);
    repeat (n) begin
      push_word($urandom_range(1, 6));
      push_text(": ", 0);
      push_word($urandom_range(0, 10));
      push_crlf();
    end
    push_crlf();
    if ($urandom_range(0, 9) == 0)
      req_q[$urandom_range(0, req_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, req_q.size() - 1);
      req_q = req_q[0:n-1];
    end
  endtask

  task automatic run_random(input int budget);
    int sent;
    int restart_at;
    sent = 0;
    while (sent < budget) begin
      make_request();
      restart_at = ($urandom_range(0, 29) == 0) ? $urandom_range(1, req_q.size()) : -1;
      send_queue($urandom_range(0, 31) != 0, restart_at);
      sent += req_q.size();
      // trailing bytes without a restart
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= '0;
    in_if.start_request <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_MAX_LINE;
    cfg_wdata           <= '0;
    burst_left          = 0;
    total_bytes         = 0;
    n_requests          = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: full request with traversal and script extension, extra method letter
    req_q.delete();
    push_text("gEt /../a.js HTTP/1.0", 0);
    push_crlf();
    push_crlf();
    send_queue(1'b1, -1);
    req_q.delete();
    push_text("GETS", 0);
    send_queue(1'b1, -1);
    send_byte(8'hFF, 1'b0);

    set_limits(16'd16, 16'd16);
    run_random(220);

    // long path and long header against a moderate limit
    set_limits(16'd48, 16'd48);
    req_q.delete();
    push_text("GET /", 0);
    send_queue(1'b1, -1);
    repeat (LONG_RUN) send_byte("a", 1'b0);
    req_q.delete();
    push_text("GET / HTTP/1.1", 0);
    push_crlf();
    send_queue(1'b1, -1);
    repeat (LONG_RUN) send_byte("h", 1'b0);

    set_limits(16'hFFFF, 16'hFFFF);
    run_random(200);

    set_limits(16'($urandom_range(16, 64)), 16'($urandom_range(16, 64)));
    hold_go = 1'b1;
    run_random(220);

    set_limits(MAX_LINE_RST, MAX_HEADER_RST);
    hold_go = 1'b1;
    run_random(220);

    set_limits(16'($urandom_range(65, 2000)), 16'($urandom_range(17, 300)));
    run_random(200);

    drain();
    $display("run covered %0d bytes in %0d requests, %0d results compared",
             total_bytes, n_requests, checked);
    $display("status codes returned (one bit per code): %b, line and header limits 16 to 65535",
             status_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
